/* design/salc_pkg.sv */
package salc_pkg;

    // Widths of the configuration fields and of the fixed result fields.
    localparam int OFFSET_W    = 5;
    localparam int INDEX_W     = 4;
    localparam int WAYS_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int WAY_OUT_W   = 2;
    localparam int COUNT_W     = 32;

    // Widest raw set index the index field can select (15 bits).
    localparam int RAW_SET_W   = 15;
    // Fraction bits of the reciprocal used to fold the set index into the store.
    localparam int RECIP_SHIFT = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd5;
    localparam logic [INDEX_W-1:0]  INDEX_RESET  = 4'd14;
    localparam logic [WAYS_W-1:0]   WAYS_RESET   = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_bits;
        logic [INDEX_W-1:0]  index_bits;
        logic [WAYS_W-1:0]   ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted;
        logic [COUNT_W-1:0]   hit_count;
        logic [COUNT_W-1:0]   miss_count;
    } result_t;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } back_state_t;

endpackage

/* design/set_assoc_lru_cache_tags_top.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    mode, address
// out       out_valid / out_ready  hit, way, evicted, hit_count, miss_count
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An access in the back end reads the set's row of tags, valid bits and ranks in the idle
// state and writes it back in the execute state; it takes no new item before that.
// An item passes the two front stages and the queue before the back end takes it.
// After reset, and after every clear item, the back end zeroes the set memory one row a
// cycle, all MAX_SETS rows; the front stages and the queue keep taking items until full.
// A stalled output holds the back end while the front keeps filling the queue.
module set_assoc_lru_cache_tags_top #(
    parameter int MAX_WAYS   = 4,
    parameter int MAX_SETS   = 16384,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [ADDR_WIDTH-1:0]            address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic [salc_pkg::WAY_OUT_W-1:0]   way,
    output logic                             evicted,
    output logic [salc_pkg::COUNT_W-1:0]     hit_count,
    output logic [salc_pkg::COUNT_W-1:0]     miss_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int QW = 1 + ADDR_WIDTH + SW;

    salc_pkg::cfg_t    cfg_reg, cfg_next;
    salc_pkg::result_t res;

    logic                  fq_valid, fq_ready, fq_mode;
    logic [ADDR_WIDTH-1:0] fq_tag;
    logic [SW-1:0]         fq_set;
    logic                  bq_valid, bq_ready;
    logic [QW-1:0]         bq_data;

    // Configuration writes are always taken; an index past the list is ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                salc_pkg::CFG_OFFSET_BITS: cfg_next.offset_bits = cfg_data;
                salc_pkg::CFG_INDEX_BITS:  cfg_next.index_bits  = cfg_data[3:0];
                salc_pkg::CFG_WAYS_IN_USE: cfg_next.ways_in_use = cfg_data[2:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= salc_pkg::OFFSET_RESET;
            cfg_reg.index_bits  <= salc_pkg::INDEX_RESET;
            cfg_reg.ways_in_use <= salc_pkg::WAYS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end splits the address into tag and set.
    salc_front #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .MAX_SETS   (MAX_SETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_mode    (mode),
        .in_address (address),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_mode     (fq_mode),
        .q_tag      (fq_tag),
        .q_set      (fq_set)
    );

    // Short queue that decouples classification from the set update.
    salc_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_mode, fq_tag, fq_set}),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (bq_data)
    );

    // The back end owns the set memory, the LRU ranks and the counters.
    salc_back #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_mode    (bq_data[QW-1]),
        .q_tag     (bq_data[SW +: ADDR_WIDTH]),
        .q_set     (bq_data[SW-1:0]),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign hit        = res.hit;
    assign way        = res.way;
    assign evicted    = res.evicted;
    assign hit_count  = res.hit_count;
    assign miss_count = res.miss_count;

endmodule

/* design/salc_ram.sv */
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/salc_queue.sv */
module salc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/salc_front.sv */
module salc_front #(
    parameter int ADDR_WIDTH = 32,
    parameter int MAX_SETS   = 16384,
    parameter int SW         = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  salc_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_mode,
    input  logic [ADDR_WIDTH-1:0] in_address,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic                  q_mode,
    output logic [ADDR_WIDTH-1:0] q_tag,
    output logic [SW-1:0]         q_set
);

    localparam int RW = salc_pkg::RAW_SET_W;
    localparam int PRODW = RW + salc_pkg::RECIP_SHIFT + 1;
    // Rounded-up reciprocal of the set count; exact quotient for any raw set index.
    localparam logic [salc_pkg::RECIP_SHIFT:0] SET_RECIP =
        (salc_pkg::RECIP_SHIFT + 1)'(((64'd1 << salc_pkg::RECIP_SHIFT) + 64'(MAX_SETS)
        - 64'd1) / 64'(MAX_SETS));

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s2_valid_reg, s2_valid_next;
    logic                  s1_mode_reg, s2_mode_reg;
    logic [ADDR_WIDTH-1:0] s1_tag_reg, s2_tag_reg;
    logic [RW-1:0]         s1_raw_reg, s2_raw_reg;
    logic [RW-1:0]         s2_quot_reg;

    logic                  accept, s1_adv, s2_go;
    logic [5:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] tag_c;
    logic [RW-1:0]         raw_c;
    logic [PRODW-1:0]      prod_c;
    logic [31:0]           rem_c;

    assign s2_go    = s2_valid_reg && q_ready;
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // A shift at or past the address width leaves a zero tag.
    assign tag_shift = 6'(cfg.offset_bits) + 6'(cfg.index_bits);
    assign tag_c     = in_address >> tag_shift;
    assign raw_c     = RW'(in_address >> cfg.offset_bits)
                     & ((RW'(1) << cfg.index_bits) - RW'(1));

    assign prod_c = PRODW'(s1_raw_reg) * PRODW'(SET_RECIP);
    assign rem_c  = 32'(s2_raw_reg) - 32'(s2_quot_reg) * 32'(MAX_SETS);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= in_mode;
            s1_tag_reg  <= tag_c;
            s1_raw_reg  <= raw_c;
        end
        if (s1_adv)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_tag_reg  <= s1_tag_reg;
            s2_raw_reg  <= s1_raw_reg;
            s2_quot_reg <= RW'(prod_c >> salc_pkg::RECIP_SHIFT);
        end
    end

    assign q_valid = s2_valid_reg;
    assign q_mode  = s2_mode_reg;
    assign q_tag   = s2_tag_reg;
    assign q_set   = SW'(rem_c);

endmodule

/* design/salc_back.sv */
module salc_back #(
    parameter int ADDR_WIDTH = 32,
    parameter int MAX_SETS   = 16384,
    parameter int MAX_WAYS   = 4,
    parameter int SW         = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  salc_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic                  q_mode,
    input  logic [ADDR_WIDTH-1:0] q_tag,
    input  logic [SW-1:0]         q_set,
    output logic                  res_valid,
    input  logic                  res_ready,
    output salc_pkg::result_t     res
);

    localparam int RKW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WW   = RKW;
    localparam int EW   = 1 + ADDR_WIDTH + RKW;
    localparam int ROWW = MAX_WAYS * EW;

    salc_pkg::back_state_t state_reg, state_next;

    logic                  item_mode_reg;
    logic [ADDR_WIDTH-1:0] item_tag_reg;
    logic [SW-1:0]         item_set_reg;
    logic [SW-1:0]         sweep_reg, sweep_next;
    logic [31:0]           hits_reg, hits_next;
    logic [31:0]           misses_reg, misses_next;
    logic                  res_valid_reg, res_valid_next;
    salc_pkg::result_t     res_reg, res_next;

    logic                  out_free;
    logic                  ram_we;
    logic [SW-1:0]         ram_waddr, ram_raddr;
    logic [ROWW-1:0]       ram_wdata, row;

    logic                  v_a   [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] t_a   [MAX_WAYS];
    logic [RKW-1:0]        r_a   [MAX_WAYS];
    logic [RKW-1:0]        r_new [MAX_WAYS];

    logic [3:0]            nways;
    logic                  found, free_hit, was_valid, evict;
    logic [WW-1:0]         hit_w, free_w, ev_w, sel_w;
    logic [RKW-1:0]        oldest, old_rank;
    logic [ROWW-1:0]       row_new;

    salc_ram #(
        .WIDTH (ROWW),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (row)
    );

    assign out_free  = !res_valid_reg || res_ready;
    assign q_ready   = (state_reg == salc_pkg::B_IDLE);
    assign ram_raddr = (state_reg == salc_pkg::B_IDLE) ? q_set : item_set_reg;

    // Lookup, victim choice and LRU aging on the row just read.
    always_comb
    begin
        nways = 4'(cfg.ways_in_use);
        if (cfg.ways_in_use == '0)
        begin
            nways = 4'd1;
        end
        else if (int'(cfg.ways_in_use) > MAX_WAYS)
        begin
            nways = 4'(MAX_WAYS);
        end

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            v_a[i] = row[i*EW + ADDR_WIDTH + RKW];
            t_a[i] = row[i*EW + RKW +: ADDR_WIDTH];
            r_a[i] = row[i*EW +: RKW];
        end

        found = 1'b0;
        hit_w = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (!found && (4'(i) < nways) && v_a[i] && (t_a[i] == item_tag_reg))
            begin
                found = 1'b1;
                hit_w = WW'(i);
            end
        end

        // The highest-numbered free way wins.
        free_hit = 1'b0;
        free_w   = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if ((4'(i) < nways) && !v_a[i])
            begin
                free_hit = 1'b1;
                free_w   = WW'(i);
            end
        end

        // The first way with the largest rank is the victim.
        oldest = r_a[0];
        ev_w   = '0;
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if ((4'(i) < nways) && (r_a[i] > oldest))
            begin
                oldest = r_a[i];
                ev_w   = WW'(i);
            end
        end

        evict = !found && !free_hit;
        sel_w = found ? hit_w : (free_hit ? free_w : ev_w);

        was_valid = v_a[sel_w];
        old_rank  = r_a[sel_w];
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            r_new[i] = r_a[i];
            if (WW'(i) == sel_w)
            begin
                r_new[i] = '0;
            end
            else if (v_a[i] && (!was_valid || (r_a[i] < old_rank)))
            begin
                r_new[i] = r_a[i] + 1'b1;
            end
        end

        row_new = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WW'(i) == sel_w)
            begin
                row_new[i*EW +: EW] = {1'b1, item_tag_reg, r_new[i]};
            end
            else
            begin
                row_new[i*EW +: EW] = {v_a[i], t_a[i], r_new[i]};
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = item_set_reg;
        ram_wdata      = row_new;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            salc_pkg::B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SW'(MAX_SETS - 1))
                begin
                    sweep_next = '0;
                    state_next = salc_pkg::B_IDLE;
                end
            end
            salc_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = salc_pkg::B_EXEC;
                end
            end
            salc_pkg::B_EXEC:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (item_mode_reg)
                    begin
                        hits_next   = '0;
                        misses_next = '0;
                        res_next    = '0;
                        sweep_next  = '0;
                        state_next  = salc_pkg::B_CLEAR;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (found && (hits_reg != salc_pkg::COUNT_MAX))
                        begin
                            hits_next = hits_reg + 1'b1;
                        end
                        if (!found && (misses_reg != salc_pkg::COUNT_MAX))
                        begin
                            misses_next = misses_reg + 1'b1;
                        end
                        res_next.hit        = found;
                        res_next.way        = salc_pkg::WAY_OUT_W'(sel_w);
                        res_next.evicted    = evict;
                        res_next.hit_count  = hits_next;
                        res_next.miss_count = misses_next;
                        state_next          = salc_pkg::B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = salc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= salc_pkg::B_CLEAR;
            sweep_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (q_valid && q_ready)
        begin
            item_mode_reg <= q_mode;
            item_tag_reg  <= q_tag;
            item_set_reg  <= q_set;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* verif/tb_set_assoc_lru_cache_tags_top.sv */
module tb_set_assoc_lru_cache_tags_top;

    localparam int NUM_WAYS  = 4;
    localparam int NUM_SETS  = 16384;
    localparam int DEPTH     = NUM_SETS * NUM_WAYS;
    // The clear sweep alone zeroes NUM_SETS rows, so the limit leaves room for
    // every clear item plus the slowest handshakes on both sides.
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 250;

    // Item kinds on the mode input.
    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    // Register index that names no register.
    localparam logic [salc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic mode;
    logic [31:0] address;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic [salc_pkg::WAY_OUT_W-1:0] way;
    logic evicted;
    logic [salc_pkg::COUNT_W-1:0] hit_count;
    logic [salc_pkg::COUNT_W-1:0] miss_count;
    logic cfg_valid;
    logic cfg_ready;
    logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [salc_pkg::CFG_DATA_W-1:0] cfg_data;

    set_assoc_lru_cache_tags_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .address(address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .way(way),
        .evicted(evicted),
        .hit_count(hit_count),
        .miss_count(miss_count),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Shadow copy of the tag store, the LRU ranks and the counters.
    bit          shadow_valid [DEPTH];
    bit [31:0]   shadow_tag   [DEPTH];
    bit [1:0]    shadow_rank  [DEPTH];
    bit [31:0]   shadow_hits;
    bit [31:0]   shadow_misses;

    // Shadow copy of the configuration registers.
    bit [salc_pkg::OFFSET_W-1:0] cur_offset_bits;
    bit [salc_pkg::INDEX_W-1:0]  cur_index_bits;
    bit [salc_pkg::WAYS_W-1:0]   cur_ways;

    // Results still owed by the block, oldest first.
    salc_pkg::result_t pending_results[$];

    int error_count;
    int cycle_count;
    bit stall_enable;

    // Directed stimulus: a row either carries a typed expectation or is left
    // to the shadow model.
    typedef struct {
        logic              kind;
        logic [31:0]       addr;
        bit                typed;
        salc_pkg::result_t want;
    } directed_row_t;

    directed_row_t directed_rows[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic void clear_shadow();
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_hits   = '0;
        shadow_misses = '0;
    endfunction

    // Make way w of the set at base the most recent; younger valid lines age.
    function automatic void promote_way(input int base, input int w);
        bit       was_valid;
        bit [1:0] old_rank;
        was_valid = shadow_valid[base + w];
        old_rank  = shadow_rank[base + w];
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (i != w && shadow_valid[base + i])
            begin
                if (!was_valid || shadow_rank[base + i] < old_rank)
                    shadow_rank[base + i]++;
            end
        end
        shadow_rank[base + w] = '0;
    endfunction

    // Computes the result of one item and advances the shadow state.
    function automatic salc_pkg::result_t lookup_and_replace(input logic kind,
                                                             input logic [31:0] addr);
        salc_pkg::result_t res;
        bit [63:0] wide_addr;
        bit [63:0] set_sel;
        bit [31:0] tag_val;
        int        shift;
        int        base;
        int        nways;
        int        found;
        int        free_way;
        int        w;
        bit [1:0]  oldest;
        res = '0;
        if (kind == MODE_CLEAR)
        begin
            clear_shadow();
            return res;
        end
        wide_addr = {32'd0, addr};
        shift = int'(cur_offset_bits) + int'(cur_index_bits);
        tag_val = (shift >= 32) ? 32'd0 : addr >> shift;
        set_sel = (wide_addr >> cur_offset_bits) & ((64'd1 << cur_index_bits) - 64'd1);
        set_sel = set_sel % NUM_SETS;
        base = int'(set_sel) * NUM_WAYS;
        nways = int'(cur_ways);
        if (nways < 1)
            nways = 1;
        if (nways > NUM_WAYS)
            nways = NUM_WAYS;
        found = -1;
        free_way = -1;
        for (int i = 0; i < nways; i++)
        begin
            if (found < 0)
            begin
                if (!shadow_valid[base + i])
                    free_way = i;
                else if (shadow_tag[base + i] == tag_val)
                    found = i;
            end
        end
        if (found >= 0)
        begin
            w = found;
            res.hit = 1'b1;
            if (shadow_hits != salc_pkg::COUNT_MAX)
                shadow_hits++;
            promote_way(base, w);
        end
        else
        begin
            if (shadow_misses != salc_pkg::COUNT_MAX)
                shadow_misses++;
            if (free_way >= 0)
            begin
                w = free_way;
            end
            else
            begin
                // Every way in use is valid: the oldest one goes, lowest way on a tie.
                w = 0;
                oldest = shadow_rank[base];
                for (int i = 1; i < nways; i++)
                begin
                    if (shadow_rank[base + i] > oldest)
                    begin
                        oldest = shadow_rank[base + i];
                        w = i;
                    end
                end
                res.evicted = 1'b1;
            end
            promote_way(base, w);
            shadow_valid[base + w] = 1'b1;
            shadow_tag[base + w] = tag_val;
        end
        res.way = w[salc_pkg::WAY_OUT_W-1:0];
        res.hit_count = shadow_hits;
        res.miss_count = shadow_misses;
        return res;
    endfunction

    // Random gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // Drives one item and holds it until accepted; the expectation is queued
    // at the acceptance edge. A gap, if any, follows with valid low.
    task automatic send_item(input logic kind, input logic [31:0] addr, input bit typed,
                             input salc_pkg::result_t want);
        salc_pkg::result_t predicted;
        int gap;
        in_valid <= 1'b1;
        mode     <= kind;
        address  <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = lookup_and_replace(kind, addr);
        pending_results.push_back(typed ? want : predicted);
        gap = stall_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [salc_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [salc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            salc_pkg::CFG_OFFSET_BITS: cur_offset_bits = data[salc_pkg::OFFSET_W-1:0];
            salc_pkg::CFG_INDEX_BITS:  cur_index_bits  = data[salc_pkg::INDEX_W-1:0];
            salc_pkg::CFG_WAYS_IN_USE: cur_ways        = data[salc_pkg::WAYS_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every owed result has come back, then lets the pipeline settle.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result checker: compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        salc_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", 32'(hit), 32'(want.hit));
                if (way !== want.way)
                    report_mismatch("way", 32'(way), 32'(want.way));
                if (evicted !== want.evicted)
                    report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
                if (hit_count !== want.hit_count)
                    report_mismatch("hit_count", hit_count, want.hit_count);
                if (miss_count !== want.miss_count)
                    report_mismatch("miss_count", miss_count, want.miss_count);
            end
        end
    end

    // Receiver back-pressure. The stalls switch on and off with stall_enable so that
    // some stretches run at full rate.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b1;
        end
        else if (!stall_enable)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(19))
                0: out_ready <= 1'b0;
                1, 2, 3: out_ready <= ~out_ready;
                default: out_ready <= ($urandom_range(9) != 0) || !out_ready;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 600 == 0)
            stall_enable <= ($urandom_range(3) != 0);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Recently used addresses, so that the random part keeps hitting and
    // evicting in the same sets instead of scattering over the whole store.
    logic [31:0] recent_addrs[32];

    function automatic logic [31:0] next_address();
        logic [31:0] a;
        int shift;
        int slot;
        int r;
        shift = int'(cur_offset_bits) + int'(cur_index_bits);
        slot = $urandom_range(31);
        r = $urandom_range(99);
        if (r < 55)
        begin
            // Same line, any byte within it.
            a = recent_addrs[slot];
            if (cur_offset_bits != 0)
                a = a ^ ($urandom & ((32'd1 << cur_offset_bits) - 32'd1));
        end
        else if (r < 85)
        begin
            // Same set, another tag: this is what fills and evicts.
            a = recent_addrs[slot];
            if (shift < 32)
                a = a ^ (($urandom_range(7) + 32'd1) << shift);
            recent_addrs[$urandom_range(31)] = a;
        end
        else
        begin
            a = $urandom;
            recent_addrs[slot] = a;
        end
        return a;
    endfunction

    // Settings walked through after the directed part: offset, index, ways.
    typedef struct {
        logic [salc_pkg::CFG_DATA_W-1:0] off;
        logic [salc_pkg::CFG_DATA_W-1:0] idx;
        logic [salc_pkg::CFG_DATA_W-1:0] nw;
    } phase_cfg_t;

    phase_cfg_t phase_list[8];

    function automatic salc_pkg::result_t mk_result(input logic h, input int w, input logic e,
                                                    input int hc, input int mc);
        salc_pkg::result_t r;
        r.hit = h;
        r.way = w[salc_pkg::WAY_OUT_W-1:0];
        r.evicted = e;
        r.hit_count = hc;
        r.miss_count = mc;
        return r;
    endfunction

    function automatic directed_row_t row(input logic k, input logic [31:0] a, input bit t,
                                          input salc_pkg::result_t w);
        directed_row_t d;
        d.kind = k;
        d.addr = a;
        d.typed = t;
        d.want = w;
        return d;
    endfunction

    initial
    begin
        salc_pkg::result_t none;
        logic kind;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_ACCESS;
        address = '0;
        cfg_valid = 1'b0;
        cfg_index = salc_pkg::CFG_OFFSET_BITS;
        cfg_data = '0;
        out_ready = 1'b1;
        error_count = 0;
        cycle_count = 0;
        stall_enable = 1'b1;
        cur_offset_bits = salc_pkg::OFFSET_RESET;
        cur_index_bits = salc_pkg::INDEX_RESET;
        cur_ways = salc_pkg::WAYS_RESET;
        clear_shadow();
        for (int i = 0; i < 32; i++)
            recent_addrs[i] = $urandom;

        phase_list[0] = '{5'd0,  5'd0,  5'd1};
        phase_list[1] = '{5'd16, 5'd14, 5'd4};
        phase_list[2] = '{5'd31, 5'd15, 5'd7};
        phase_list[3] = '{5'd4,  5'd3,  5'd2};
        phase_list[4] = '{5'd0,  5'd15, 5'd0};
        phase_list[5] = '{5'd31, 5'd0,  5'd3};
        phase_list[6] = '{5'd20, 5'd30, 5'd5};
        phase_list[7] = '{5'd2,  5'd2,  5'd4};

        // Reset settings: offset 5, index 14, four ways. The first access
        // fills the highest way; the same line then hits there.
        directed_rows.push_back(row(MODE_ACCESS, 32'h0000_0000, 1, mk_result(0, 3, 0, 0, 1)));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0000_001F, 1, mk_result(1, 3, 0, 1, 1)));
        directed_rows.push_back(row(MODE_ACCESS, 32'hFFFF_FFFF, 1, mk_result(0, 3, 0, 1, 2)));
        // A clear empties everything and zeroes the counters.
        directed_rows.push_back(row(MODE_CLEAR, 32'hFFFF_FFFF, 1, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'hFFFF_FFFF, 1, mk_result(0, 3, 0, 0, 1)));
        // Fill one set with four tags, touch one, then push out the oldest.
        directed_rows.push_back(row(MODE_ACCESS, 32'h0008_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0010_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0018_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0020_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0008_0050, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0028_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0030_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0010_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h0008_0040, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h8000_0000, 0, none));
        directed_rows.push_back(row(MODE_ACCESS, 32'h7FFF_FFFF, 0, none));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].typed,
                      directed_rows[i].want);

        // Duplicate tags: with a wide offset every tag becomes zero, so lines
        // left from before may match more than once; the lowest way wins.
        wait_until_idle();
        write_register(salc_pkg::CFG_OFFSET_BITS, 5'd31);
        write_register(salc_pkg::CFG_INDEX_BITS, 5'd15);
        send_item(MODE_ACCESS, 32'h0000_0000, 0, none);
        send_item(MODE_ACCESS, 32'hFFFF_FFFF, 0, none);
        send_item(MODE_ACCESS, 32'h8000_0000, 0, none);
        // A write to the unused register index changes nothing.
        wait_until_idle();
        write_register(CFG_UNUSED_INDEX, 5'd31);
        send_item(MODE_ACCESS, 32'h1234_5678, 0, none);

        foreach (phase_list[p])
        begin
            wait_until_idle();
            write_register(salc_pkg::CFG_OFFSET_BITS, phase_list[p].off);
            write_register(salc_pkg::CFG_INDEX_BITS, phase_list[p].idx);
            write_register(salc_pkg::CFG_WAYS_IN_USE, phase_list[p].nw);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once a phase, the sender holds off until the block has
                // drained completely.
                if (n == ITEMS_PER_PHASE / 2)
                begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                kind = ($urandom_range(299) == 0) ? MODE_CLEAR : MODE_ACCESS;
                send_item(kind, next_address(), 0, none);
            end
        end

        wait_until_idle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/salc_pkg.sv
design/salc_ram.sv
design/salc_queue.sv
design/salc_front.sv
design/salc_back.sv
design/set_assoc_lru_cache_tags_top.sv
verif/tb_set_assoc_lru_cache_tags_top.sv
